### src/gmr_pkg.sv
// Shared types, constants and the control program of the grid maze reachability block.
package gmr_pkg;

  // Defaults and port widths
  localparam int GRID_SIZE_DEF = 16;
  localparam int S_DATA_W      = 16;
  localparam int M_DATA_W      = 8;

  // Sequencer step addresses
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t ST_WCLR  = 4'd0;
  localparam upc_t ST_IDLE  = 4'd1;
  localparam upc_t ST_VCLR  = 4'd2;
  localparam upc_t ST_START = 4'd3;
  localparam upc_t ST_POP   = 4'd4;
  localparam upc_t ST_LOAD  = 4'd5;
  localparam upc_t ST_NEIGH = 4'd6;
  localparam upc_t ST_CHECK = 4'd7;
  localparam upc_t ST_DIRS  = 4'd8;
  localparam upc_t ST_LOOP  = 4'd9;
  localparam upc_t ST_FAIL  = 4'd10;
  localparam upc_t ST_PASS  = 4'd11;
  localparam upc_t ST_EMIT  = 4'd12;
  localparam upc_t ST_DONE  = 4'd13;

  // Datapath operations
  typedef logic [3:0] uop_t;

  localparam uop_t OP_NOP    = 4'd0;
  localparam uop_t OP_WCLR   = 4'd1;
  localparam uop_t OP_IDLE   = 4'd2;
  localparam uop_t OP_VCLR   = 4'd3;
  localparam uop_t OP_START  = 4'd4;
  localparam uop_t OP_POP    = 4'd5;
  localparam uop_t OP_LOAD   = 4'd6;
  localparam uop_t OP_NEIGH  = 4'd7;
  localparam uop_t OP_CHECK  = 4'd8;
  localparam uop_t OP_DIRINC = 4'd9;
  localparam uop_t OP_RES0   = 4'd10;
  localparam uop_t OP_RES1   = 4'd11;
  localparam uop_t OP_EMIT   = 4'd12;

  // Jump conditions
  typedef logic [2:0] cond_t;

  localparam cond_t C_NEVER    = 3'd0;
  localparam cond_t C_ALWAYS   = 3'd1;
  localparam cond_t C_CLR_MORE = 3'd2;
  localparam cond_t C_NO_START = 3'd3;
  localparam cond_t C_SP_ZERO  = 3'd4;
  localparam cond_t C_FOUND    = 3'd5;
  localparam cond_t C_DIR_MORE = 3'd6;
  localparam cond_t C_OUT_BUSY = 3'd7;

  // One control word: operation, jump condition, jump target
  typedef struct packed {
    uop_t  op;
    cond_t cond;
    upc_t  target;
  } ucode_t;

  // Neighbor order: east, west, north, south
  typedef logic signed [1:0] delta_t;
  localparam delta_t STEP_DX [4] = '{2'sb01, 2'sb11, 2'sb00, 2'sb00};
  localparam delta_t STEP_DY [4] = '{2'sb00, 2'sb00, 2'sb01, 2'sb11};
  localparam logic [1:0] WALL_BIT [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

  // Control program
  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t w;
    case (pc)
      ST_WCLR:  w = '{op: OP_WCLR,   cond: C_CLR_MORE, target: ST_WCLR};
      ST_IDLE:  w = '{op: OP_IDLE,   cond: C_NO_START, target: ST_IDLE};
      ST_VCLR:  w = '{op: OP_VCLR,   cond: C_CLR_MORE, target: ST_VCLR};
      ST_START: w = '{op: OP_START,  cond: C_NEVER,    target: ST_POP};
      ST_POP:   w = '{op: OP_POP,    cond: C_SP_ZERO,  target: ST_FAIL};
      ST_LOAD:  w = '{op: OP_LOAD,   cond: C_NEVER,    target: ST_NEIGH};
      ST_NEIGH: w = '{op: OP_NEIGH,  cond: C_NEVER,    target: ST_CHECK};
      ST_CHECK: w = '{op: OP_CHECK,  cond: C_FOUND,    target: ST_PASS};
      ST_DIRS:  w = '{op: OP_DIRINC, cond: C_DIR_MORE, target: ST_NEIGH};
      ST_LOOP:  w = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_POP};
      ST_FAIL:  w = '{op: OP_RES0,   cond: C_ALWAYS,   target: ST_EMIT};
      ST_PASS:  w = '{op: OP_RES1,   cond: C_NEVER,    target: ST_EMIT};
      ST_EMIT:  w = '{op: OP_EMIT,   cond: C_OUT_BUSY, target: ST_EMIT};
      ST_DONE:  w = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_IDLE};
      default:  w = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

### src/grid_maze_reachability_dfs_top.sv
// Grid maze reachability block: wall store, visited map, search stack and control sequencer.
// Usage
//   Input channel s_*: one item per handshake. s_tuser is the operation (0 stores the
//   wall bits of a cell, 1 asks whether the centre cell can be reached from a start cell).
//   Output channel m_*: one item per query, m_tdata[0] is the reachable flag.
// Throughput and search sequence
//   Wall writes are taken while the block is idle and the output register is free;
//   under that condition writes can follow each other every cycle. A query that starts
//   at the centre or off the grid answers in the output register on the next cycle.
//   Any other query first clears the visited map, then the search walks popped cells:
//   it pops a cell and fetches its walls, tries each of the four neighbors in turn
//   (move test and visited read, check, direction step), then loops. The step sequencer
//   with its memories (one write and one read port each) handles one query at a time.
// Reset
//   After rst the wall store is swept to zero, one cell per cycle;
//   s_tready stays low during that sweep.
// Stall
//   A result waits in the output register while m_tready is low; new items are still
//   taken while the block is idle, but only when the output register is free or
//   drains in the same cycle.
module grid_maze_reachability_dfs_top #(
  parameter int GRID_SIZE = gmr_pkg::GRID_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // cell_x [3:0], cell_y [7:4], wall_bits [11:8], margin [15:12]
  input  logic [gmr_pkg::S_DATA_W-1:0]  s_tdata,
  // op [0]
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // reachable [0], zeros above
  output logic [gmr_pkg::M_DATA_W-1:0]  m_tdata
);

  localparam int CW    = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int IW    = $clog2(CELLS);
  localparam int SPW   = $clog2(CELLS + 1);
  localparam int VW    = CW + 6;
  localparam int SW    = 2 * CW;
  localparam logic [CW-1:0] CTR = CW'(GRID_SIZE / 2);

  // Row-major cell address
  function automatic logic [IW-1:0] cell_index(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y);
    cell_index = IW'(int'(y) * GRID_SIZE + int'(x));
  endfunction

  // Sequencer
  gmr_pkg::upc_t   upc;
  gmr_pkg::upc_t   upc_next;
  gmr_pkg::ucode_t word;
  logic            jump;

  // Datapath registers
  logic [CW-1:0]  cx, cy, nx, ny;
  logic           nok;
  logic [1:0]     dir;
  logic [SPW-1:0] sp;
  logic [IW-1:0]  clr;
  logic [3:0]     margin_r;
  logic           res;
  logic           out_data;
  logic           out_valid;

  // Memories
  logic [3:0]    wall_mem [CELLS];
  logic          vis_mem  [CELLS];
  logic [SW-1:0] stk_mem  [CELLS];
  logic [3:0]    wall_q;
  logic          vis_q;
  logic [SW-1:0] stk_q;

  logic          wall_we, wall_re;
  logic [IW-1:0] wall_waddr, wall_raddr;
  logic [3:0]    wall_wdata;
  logic          vis_we, vis_re, vis_wdata;
  logic [IW-1:0] vis_waddr, vis_raddr;
  logic          stk_we, stk_re;
  logic [IW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata;

  // Input decode
  logic                 s_fire;
  logic signed [VW-1:0] in_xv, in_yv, gsz;
  logic [CW-1:0]        in_xc, in_yc;
  logic                 in_grid, start_centre, start_go, imm_load;
  logic                 out_free, emit_load;

  // Neighbor check
  logic signed [VW-1:0] ex, ey, lo_v, hi_v;
  logic                 n_ok, found, push;
  logic                 clr_last, sp_room;
  logic [SPW-1:0]       sp_dec;

  assign word     = gmr_pkg::ucode_rom(upc);
  assign out_free = !out_valid || m_tready;
  assign s_tready = (upc == gmr_pkg::ST_IDLE) && out_free;
  assign s_fire   = s_tvalid && s_tready;

  assign gsz          = VW'(GRID_SIZE);
  assign in_xv        = VW'(s_tdata[3:0]);
  assign in_yv        = VW'(s_tdata[7:4]);
  assign in_xc        = in_xv[CW-1:0];
  assign in_yc        = in_yv[CW-1:0];
  assign in_grid      = (in_xv < gsz) && (in_yv < gsz);
  assign start_centre = (in_xv == VW'(GRID_SIZE / 2)) && (in_yv == VW'(GRID_SIZE / 2));
  assign start_go     = s_fire && s_tuser && !start_centre && in_grid;
  assign imm_load     = s_fire && s_tuser && (start_centre || !in_grid);
  assign emit_load    = (word.op == gmr_pkg::OP_EMIT) && out_free;

  // Neighbor coordinates and move test for the current direction
  assign ex   = VW'(cx) + VW'(gmr_pkg::STEP_DX[dir]);
  assign ey   = VW'(cy) + VW'(gmr_pkg::STEP_DY[dir]);
  assign lo_v = VW'(margin_r);
  assign hi_v = gsz - lo_v;
  assign n_ok = !wall_q[gmr_pkg::WALL_BIT[dir]]
             && (ex >= lo_v) && (ex < hi_v) && (ey >= lo_v) && (ey < hi_v)
             && (ex >= 0) && (ey >= 0) && (ex < gsz) && (ey < gsz);

  assign found    = nok && !vis_q && (nx == CTR) && (ny == CTR);
  assign push     = nok && !vis_q && !found;
  assign clr_last = (clr == IW'(CELLS - 1));
  assign sp_room  = (sp < SPW'(CELLS));
  assign sp_dec   = sp - 1'b1;

  // Jump decision and next step
  always_comb begin
    case (word.cond)
      gmr_pkg::C_NEVER:    jump = 1'b0;
      gmr_pkg::C_ALWAYS:   jump = 1'b1;
      gmr_pkg::C_CLR_MORE: jump = !clr_last;
      gmr_pkg::C_NO_START: jump = !start_go;
      gmr_pkg::C_SP_ZERO:  jump = (sp == '0);
      gmr_pkg::C_FOUND:    jump = found;
      gmr_pkg::C_DIR_MORE: jump = (dir != 2'd3);
      gmr_pkg::C_OUT_BUSY: jump = !out_free;
      default:             jump = 1'b0;
    endcase
    upc_next = jump ? word.target : upc + 1'b1;
  end

  // Memory port control
  always_comb begin
    wall_we    = 1'b0;
    wall_re    = 1'b0;
    wall_waddr = clr;
    wall_raddr = cell_index(stk_q[CW-1:0], stk_q[SW-1:CW]);
    wall_wdata = '0;
    vis_we     = 1'b0;
    vis_re     = 1'b0;
    vis_waddr  = clr;
    vis_raddr  = cell_index(ex[CW-1:0], ey[CW-1:0]);
    vis_wdata  = 1'b0;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    stk_waddr  = sp[IW-1:0];
    stk_raddr  = sp_dec[IW-1:0];
    stk_wdata  = {ny, nx};
    case (word.op)
      gmr_pkg::OP_WCLR: begin
        wall_we = 1'b1;
      end
      gmr_pkg::OP_IDLE: begin
        wall_we    = s_fire && !s_tuser && in_grid;
        wall_waddr = cell_index(in_xc, in_yc);
        wall_wdata = s_tdata[11:8];
      end
      gmr_pkg::OP_VCLR: begin
        vis_we = 1'b1;
      end
      gmr_pkg::OP_START: begin
        vis_we    = 1'b1;
        vis_waddr = cell_index(cx, cy);
        vis_wdata = 1'b1;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = {cy, cx};
      end
      gmr_pkg::OP_POP: begin
        stk_re = (sp != '0);
      end
      gmr_pkg::OP_LOAD: begin
        wall_re = 1'b1;
      end
      gmr_pkg::OP_NEIGH: begin
        vis_re = n_ok;
      end
      gmr_pkg::OP_CHECK: begin
        vis_we    = push;
        vis_waddr = cell_index(nx, ny);
        vis_wdata = 1'b1;
        stk_we    = push && sp_room;
      end
      default: begin
      end
    endcase
  end

  // Wall store
  always_ff @(posedge clk) begin
    if (wall_we) wall_mem[wall_waddr] <= wall_wdata;
    if (wall_re) wall_q <= wall_mem[wall_raddr];
  end

  // Visited map
  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    if (vis_re) vis_q <= vis_mem[vis_raddr];
  end

  // Search stack
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_q <= stk_mem[stk_raddr];
  end

  // Step counter and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= gmr_pkg::ST_WCLR;
      clr <= '0;
      sp  <= '0;
    end else begin
      upc <= upc_next;
      case (word.op)
        gmr_pkg::OP_WCLR, gmr_pkg::OP_VCLR: begin
          clr <= clr_last ? '0 : clr + 1'b1;
        end
        gmr_pkg::OP_START: begin
          sp <= SPW'(1);
        end
        gmr_pkg::OP_POP: begin
          if (sp != '0) sp <= sp_dec;
        end
        gmr_pkg::OP_CHECK: begin
          if (push && sp_room) sp <= sp + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Search datapath registers
  always_ff @(posedge clk) begin
    case (word.op)
      gmr_pkg::OP_IDLE: begin
        if (start_go) begin
          cx       <= in_xc;
          cy       <= in_yc;
          margin_r <= s_tdata[15:12];
        end
      end
      gmr_pkg::OP_LOAD: begin
        cx  <= stk_q[CW-1:0];
        cy  <= stk_q[SW-1:CW];
        dir <= 2'd0;
      end
      gmr_pkg::OP_NEIGH: begin
        nx  <= ex[CW-1:0];
        ny  <= ey[CW-1:0];
        nok <= n_ok;
      end
      gmr_pkg::OP_DIRINC: dir <= dir + 1'b1;
      gmr_pkg::OP_RES0:   res <= 1'b0;
      gmr_pkg::OP_RES1:   res <= 1'b1;
      default: begin
      end
    endcase
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (imm_load || emit_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (imm_load) begin
      out_data <= start_centre;
    end else if (emit_load) begin
      out_data <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(gmr_pkg::M_DATA_W-1){1'b0}}, out_data};

endmodule

### src/gmr_checker.sv
// Port-level checker for the grid maze reachability block and its bind.
module gmr_checker #(
  parameter int GRID_SIZE = gmr_pkg::GRID_SIZE_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [gmr_pkg::S_DATA_W-1:0] s_tdata,
  input logic                         s_tuser,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [gmr_pkg::M_DATA_W-1:0] m_tdata
);

  // Input is only taken when the output register can accept a result
  a_ready_out_free: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("input taken while output register is blocked");

  // A write never creates a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser && !m_tvalid) |=> !m_tvalid)
    else $error("wall write produced a result item");

  // A query starting at the centre answers one on the next cycle
  a_centre_hit: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser
     && (int'(s_tdata[3:0]) == GRID_SIZE / 2)
     && (int'(s_tdata[7:4]) == GRID_SIZE / 2)) |=> (m_tvalid && m_tdata[0]))
    else $error("centre start did not answer reachable");

  // Only the flag bit of the result carries data
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[gmr_pkg::M_DATA_W-1:1] == '0))
    else $error("result padding bits not zero");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind grid_maze_reachability_dfs_top gmr_checker #(.GRID_SIZE(GRID_SIZE)) u_gmr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
